>>> rtl/sbam_pkg.sv
// Shared types and constants for the sequence best anchor match core.
// No dependencies; imported by every module of the block.
package sbam_pkg;

  localparam int ELEM_W     = 16;
  localparam int TERM_W     = 34;   // 17 x 17 bit signed product
  localparam int SCORE_W    = 48;

  localparam int MAX_VECTOR_LEN_DEF = 256;
  localparam int QUEUE_DEPTH_DEF    = 4;

  localparam logic signed [SCORE_W-1:0] SUM_MAX  = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [SCORE_W-1:0] SUM_MIN  = 48'sh8000_0000_0000;
  // largest distance negated
  localparam logic signed [SCORE_W-1:0] DIST_SENT = 48'sh8000_0000_0001;

  localparam logic MODE_DOT  = 1'b0;
  localparam logic MODE_DIST = 1'b1;

  // classified request handed from front to back
  typedef struct packed {
    logic signed [TERM_W-1:0] term;
    logic                     add_en;
    logic                     last_el;
    logic                     last_vec;
    logic                     missing;
  } sbam_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } sbam_q_status_t;

  typedef struct packed {
    logic pop;
    logic busy;   // compare stage holds a request
  } sbam_back_status_t;

  function automatic logic signed [SCORE_W-1:0] sentinel_of(input logic mode);
    return (mode == MODE_DIST) ? DIST_SENT : SUM_MIN;
  endfunction

endpackage

>>> rtl/sbam_front.sv
// Front end: classifies each accepted request and forms its term (product or
// squared difference). Depends on sbam_pkg.
module sbam_front #(
  parameter int MAX_VECTOR_LEN = sbam_pkg::MAX_VECTOR_LEN_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                accept,
  input  logic                                reduce_mode,
  input  logic signed [sbam_pkg::ELEM_W-1:0]  vec_elem,
  input  logic signed [sbam_pkg::ELEM_W-1:0]  anchor_elem,
  input  logic                                last_element,
  input  logic                                last_vector,
  input  logic                                missing,
  output sbam_pkg::sbam_item_t                item
);
  import sbam_pkg::*;

  localparam int CNT_W = $clog2(MAX_VECTOR_LEN + 1);

  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        count_next;
  logic                    add_en;
  logic signed [ELEM_W:0]  diff;
  logic signed [ELEM_W:0]  op_x;
  logic signed [ELEM_W:0]  op_y;
  logic signed [TERM_W-1:0] prod;

  assign add_en = (count < CNT_W'(MAX_VECTOR_LEN));

  // one shared multiplier: a*b for dot, d*d for distance
  assign diff = {vec_elem[ELEM_W-1], vec_elem} - {anchor_elem[ELEM_W-1], anchor_elem};
  assign op_x = (reduce_mode == MODE_DIST) ? diff : {vec_elem[ELEM_W-1], vec_elem};
  assign op_y = (reduce_mode == MODE_DIST) ? diff : {anchor_elem[ELEM_W-1], anchor_elem};
  assign prod = op_x * op_y;

  always_comb begin
    count_next = count;
    if (accept) begin
      if (missing || last_element) begin
        count_next = '0;
      end else if (add_en) begin
        count_next = count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_comb begin
    item.term     = prod;
    item.add_en   = add_en;
    item.last_el  = last_element;
    item.last_vec = last_vector;
    item.missing  = missing;
  end

endmodule

>>> rtl/sbam_queue.sv
// Short request queue between front and back, registered entries.
// Depends on sbam_pkg.
module sbam_queue #(
  parameter int DEPTH = sbam_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  sbam_pkg::sbam_item_t     wr_item,
  input  logic                     pop,
  output sbam_pkg::sbam_item_t     rd_item,
  output sbam_pkg::sbam_q_status_t status
);
  import sbam_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  sbam_item_t       entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wrap_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= wrap_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_item;
    end
  end

  assign rd_item      = entries[rd_ptr];
  assign status.full  = (count == CNT_W'(DEPTH));
  assign status.empty = (count == '0);

endmodule

>>> rtl/sbam_back.sv
// Back end: accumulates vector sums, compares finished vectors with the
// best so far and holds the score for the output. Depends on sbam_pkg.
module sbam_back (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  reduce_mode,
  input  sbam_pkg::sbam_item_t                  head,
  input  sbam_pkg::sbam_q_status_t              q_status,
  input  logic                                  out_ready,
  output logic                                  out_valid,
  output logic signed [sbam_pkg::SCORE_W-1:0]   out_score,
  output sbam_pkg::sbam_back_status_t           status
);
  import sbam_pkg::*;

  // accumulate stage
  logic signed [SCORE_W-1:0] running_sum;
  logic signed [SCORE_W:0]   acc_wide;
  logic signed [SCORE_W-1:0] acc_sat;
  logic signed [SCORE_W-1:0] sum_new;
  logic                      head_needs_b;
  logic                      pop;

  // compare stage
  logic                      b_valid;
  logic signed [SCORE_W-1:0] b_sum;
  logic                      b_last_vec;
  logic                      b_missing;
  logic                      b_emits;
  logic                      b_fire;
  logic                      out_free;

  logic signed [SCORE_W-1:0] best_value;
  logic                      have_best;
  logic signed [SCORE_W-1:0] cand;
  logic signed [SCORE_W-1:0] best_next;
  logic signed [SCORE_W-1:0] final_score;

  assign acc_wide = {running_sum[SCORE_W-1], running_sum}
                  + {{(SCORE_W + 1 - TERM_W){head.term[TERM_W-1]}}, head.term};

  always_comb begin
    if (acc_wide[SCORE_W] != acc_wide[SCORE_W-1]) begin
      acc_sat = acc_wide[SCORE_W] ? SUM_MIN : SUM_MAX;
    end else begin
      acc_sat = acc_wide[SCORE_W-1:0];
    end
    sum_new = head.add_en ? acc_sat : running_sum;
  end

  assign out_free     = !out_valid || out_ready;
  assign b_emits      = b_missing || b_last_vec;
  assign b_fire       = b_valid && (!b_emits || out_free);
  assign head_needs_b = head.last_el || head.missing;
  assign pop          = !q_status.empty && (!head_needs_b || !b_valid || b_fire);

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
    end else if (pop) begin
      running_sum <= head_needs_b ? '0 : sum_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (pop && head_needs_b) begin
      b_valid <= 1'b1;
    end else if (b_fire) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head_needs_b) begin
      b_sum      <= sum_new;
      b_last_vec <= head.last_vec;
      b_missing  <= head.missing;
    end
  end

  // candidate in score form; negating the most negative sum saturates
  always_comb begin
    if (reduce_mode == MODE_DIST) begin
      cand = (b_sum == SUM_MIN) ? SUM_MAX : -b_sum;
    end else begin
      cand = b_sum;
    end
    best_next   = (!have_best || cand > best_value) ? cand : best_value;
    // a dot-mode floor value ending a distance-mode example lifts to its sentinel
    final_score = ((reduce_mode == MODE_DIST) && (best_next == SUM_MIN)) ? DIST_SENT
                                                                         : best_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_value <= SUM_MIN;
      have_best  <= 1'b0;
    end else if (b_fire) begin
      if (b_emits) begin
        best_value <= sentinel_of(reduce_mode);
        have_best  <= 1'b0;
      end else begin
        best_value <= best_next;
        have_best  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_fire && b_emits) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_fire && b_emits) begin
      out_score <= b_missing ? sentinel_of(reduce_mode) : final_score;
    end
  end

  assign status.pop  = pop;
  assign status.busy = b_valid;

endmodule

>>> rtl/sequence_best_anchor_match_core.sv
// Top level of the sequence best anchor match core: mode register, front end,
// request queue and back end. Depends on sbam_pkg, sbam_front, sbam_queue and
// sbam_back.
//
// Use:
//   Slave stream s_*: one element pair per request. s_tdata holds vec_elem
//   and anchor_elem, s_tlast marks the last element of a vector, s_tuser
//   carries last_vector and missing. Master stream m_*: one 48-bit signed score
//   per example, at the last element of its last vector or at a missing flag.
//   cfg_*: writes reduce_mode (0 = max dot product, 1 = negated min squared
//   distance); always ready, to be written only while the block is drained.
// Path: the request that ends an example is written into the queue, popped into
//   the compare stage, and from there its score is registered onto m_tdata.
// Throughput: one request per cycle while s_tready is high; the accumulate loop is
//   a single 48-bit saturating add per cycle and the multiplier runs once per request.
// Reset: rst clears the mode to dot, the queue, the sums and the output.
// Stall: while m_tready is low the score holds; the back end keeps summing until
//   the compare stage holds the next score and a further vector end reaches it,
//   then the queue fills and s_tready drops.
module sequence_best_anchor_match_core #(
  parameter int MAX_VECTOR_LEN = sbam_pkg::MAX_VECTOR_LEN_DEF,
  parameter int QUEUE_DEPTH    = sbam_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // slave stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [15:0] vec_elem, [31:16] anchor_elem
  input  logic        s_tlast,   // last_element
  input  logic [1:0]  s_tuser,   // [0] last_vector, [1] missing
  // master stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [47:0] score
  // mode register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);
  import sbam_pkg::*;

  logic              reduce_mode;
  logic              accept;
  sbam_item_t        front_item;
  sbam_item_t        head_item;
  sbam_q_status_t    q_status;
  sbam_back_status_t b_status;
  logic signed [SCORE_W-1:0] score;

  // mode register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      reduce_mode <= MODE_DOT;
    end else if (cfg_valid && cfg_ready) begin
      reduce_mode <= cfg_data;
    end
  end

  assign s_tready = !q_status.full;
  assign accept   = s_tvalid && s_tready;

  sbam_front #(
    .MAX_VECTOR_LEN (MAX_VECTOR_LEN)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .reduce_mode  (reduce_mode),
    .vec_elem     (s_tdata[15:0]),
    .anchor_elem  (s_tdata[31:16]),
    .last_element (s_tlast),
    .last_vector  (s_tuser[0]),
    .missing      (s_tuser[1]),
    .item         (front_item)
  );

  sbam_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (accept),
    .wr_item (front_item),
    .pop     (b_status.pop),
    .rd_item (head_item),
    .status  (q_status)
  );

  sbam_back u_back (
    .clk         (clk),
    .rst         (rst),
    .reduce_mode (reduce_mode),
    .head        (head_item),
    .q_status    (q_status),
    .out_ready   (m_tready),
    .out_valid   (m_tvalid),
    .out_score   (score),
    .status      (b_status)
  );

  assign m_tdata = score;

  // reset leaves no score pending and an empty queue
  a_reset_clears: assert property (@(posedge clk)
    rst |=> (!m_tvalid && q_status.empty))
    else $error("state not cleared after reset");

  // a new score comes only out of the compare stage
  a_score_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(b_status.busy))
    else $error("score appeared without a compare stage request");

  // back end never pops an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    b_status.pop |-> !q_status.empty)
    else $error("queue popped while empty");

endmodule

>>> sim/sequence_best_anchor_match_core_test.sv
// Self-checking bench for sequence_best_anchor_match_core: max dot product and
// negated min squared distance scoring, checked against an in-bench predictor.
// Needs sbam_pkg and the core RTL only.
`timescale 1ns / 100ps

module sequence_best_anchor_match_core_test;

  import sbam_pkg::*;

  localparam int    VEC_LEN_CAP = MAX_VECTOR_LEN_DEF;
  localparam int    CYCLE_LIMIT = 200000;
  localparam int    IDLE_PCT    = 38;
  localparam int    DRAIN_GAP   = 8;     // margin after the last owed score comes back
  localparam int    STALL_LEN   = 150;
  localparam longint SAT_HI     = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SAT_LO     = -SAT_HI - 1;

  // one element pair request as the stream carries it
  typedef struct {
    logic signed [15:0] vec;
    logic signed [15:0] anc;
    bit                 last_el;
    bit                 last_vec;
    bit                 missing;
  } elem_req_t;

  // Predictor plus store of scores still owed by the block
  class anchor_score_board;
    logic          mode;
    longint        run_sum;
    longint        best;
    bit            have_best;
    int            elem_cnt;
    logic [47:0]   owed_scores[$];
    int            errors;
    int            checked;
    int            sentinels;
    int            dot_scores;
    int            dist_scores;

    function new();
      mode = MODE_DOT;
      restart();
    endfunction

    function longint sentinel();
      return (mode == MODE_DIST) ? -SAT_HI : SAT_LO;
    endfunction

    function longint sat(longint v);
      if (v > SAT_HI) return SAT_HI;
      if (v < SAT_LO) return SAT_LO;
      return v;
    endfunction

    function void restart();
      run_sum   = 0;
      elem_cnt  = 0;
      best      = sentinel();
      have_best = 0;
    endfunction

    function void set_mode(logic m);
      mode = m;
    endfunction

    function void owe(longint s);
      owed_scores.push_back(s[47:0]);
      if (s == sentinel()) sentinels++;
      if (mode == MODE_DIST) dist_scores++;
      else dot_scores++;
    endfunction

    function int pending();
      return owed_scores.size();
    endfunction

    function void note_request(elem_req_t r);
      longint term;
      longint cand;
      longint s;
      if (r.missing) begin
        owe(sentinel());
        restart();
        return;
      end
      // elements past the cap are dropped, their flags still count
      if (elem_cnt < VEC_LEN_CAP) begin
        if (mode == MODE_DIST) begin
          term = longint'(r.vec) - longint'(r.anc);
          term = term * term;
        end else begin
          term = longint'(r.vec) * longint'(r.anc);
        end
        run_sum = sat(run_sum + term);
        elem_cnt++;
      end
      if (!r.last_el) return;
      cand = sat((mode == MODE_DIST) ? -run_sum : run_sum);
      if (mode == MODE_DIST && cand < -SAT_HI) cand = -SAT_HI;
      if (!have_best || cand > best) best = cand;
      have_best = 1;
      run_sum   = 0;
      elem_cnt  = 0;
      if (!r.last_vec) return;
      s = have_best ? best : sentinel();
      if (s < sentinel()) s = sentinel();
      owe(s);
      restart();
    endfunction

    function void check_score(logic [47:0] got);
      logic [47:0] want;
      if (owed_scores.size() == 0) begin
        errors++;
        $display("%0t: unexpected score: expected none, actual %0d", $time, $signed(got));
        return;
      end
      want = owed_scores.pop_front();
      checked++;
      if (got !== want) begin
        errors++;
        $display("%0t: score mismatch: expected %0d, actual %0d",
                 $time, $signed(want), $signed(got));
      end
    endfunction
  endclass

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata   = '0;   // [15:0] vec_elem, [31:16] anchor_elem
  logic        s_tlast   = 1'b0; // last_element
  logic [1:0]  s_tuser   = '0;   // [0] last_vector, [1] missing
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [47:0] m_tdata;          // [47:0] score
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data  = 1'b0;

  anchor_score_board sb = new();

  int  cycles    = 0;
  int  sent      = 0;
  int  hold_left = 0;   // receiver hold-off, counted down in the receiver process
  bit  calm      = 0;   // no idling on either side
  bit  push_hard = 0;   // sender only: no gaps
  int  long_len  = 0;

  sequence_best_anchor_match_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Receiver: outputs are read right after the edge, so they still hold the
  // values the block presented at that edge. m_tready is then redrawn.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) sb.check_score(m_tdata);
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        m_tready <= 1'b0;
      end else if (calm) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Offer one request, idling first at random; s_tvalid stays high on return
  // so a back-to-back request needs no second assignment in the same step.
  task automatic send_req(input logic [15:0] vec, input logic [15:0] anc,
                          input bit last_el, input bit last_vec, input bit missing);
    elem_req_t r;
    r.vec      = vec;
    r.anc      = anc;
    r.last_el  = last_el;
    r.last_vec = last_vec;
    r.missing  = missing;
    while (!calm && !push_hard && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {anc, vec};
    s_tlast  <= last_el;
    s_tuser  <= {missing, last_vec};
    do @(posedge clk); while (!s_tready);
    sb.note_request(r);
    sent++;
  endtask

  // sender pauses until every owed score has come back
  task automatic wait_drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // drained, plus a margin for requests that owe no score but may still be
  // in the accumulator pipe
  task automatic wait_quiet();
    wait_drain();
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    wait_quiet();
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    sb.set_mode(m);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // element values lean on the extremes, the rest fully random
  function automatic logic [15:0] pick_elem();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom());
    endcase
  endfunction

  // Mostly well-formed examples with random content; some missing flags,
  // some noise that leaves partial examples or stray last_vector bits.
  task automatic random_example();
    int kind;
    int nvec;
    int len;
    int v;
    int e;
    kind = $urandom_range(99);
    if (kind < 8) begin
      send_req(pick_elem(), pick_elem(), 1'($urandom_range(1)), 1'($urandom_range(1)), 1'b1);
    end else if (kind < 16) begin
      repeat ($urandom_range(1, 3))
        send_req(pick_elem(), pick_elem(), 1'($urandom_range(1)), 1'($urandom_range(1)),
                 $urandom_range(3) == 0);
    end else begin
      nvec = $urandom_range(1, 4);
      for (v = 0; v < nvec; v++) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 5);
        for (e = 0; e < len; e++)
          send_req(pick_elem(), pick_elem(), e == len - 1,
                   (e == len - 1) ? (v == nvec - 1) : ($urandom_range(15) == 0), 1'b0);
      end
    end
  endtask

  // vector past the length cap: tail elements must not be summed
  task automatic long_vector(input int len);
    int e;
    for (e = 0; e < len; e++)
      send_req(pick_elem(), pick_elem(), e == len - 1, e == len - 1, 1'b0);
  endtask

  initial begin
    int k;
    int chunk_end;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed: dot mode ----
    write_mode(MODE_DOT);
    send_req(16'h7FFF, 16'h7FFF, 1'b1, 1'b1, 1'b0);   // product of the largest positive elements
    send_req(16'h8000, 16'h8000, 1'b1, 1'b0, 1'b0);   // two vectors, first wins
    send_req(16'h8000, 16'h7FFF, 1'b1, 1'b1, 1'b0);
    send_req(16'h0003, 16'h0004, 1'b1, 1'b0, 1'b0);   // tie: equal vectors
    send_req(16'h0004, 16'h0003, 1'b1, 1'b1, 1'b0);
    send_req(16'h1234, 16'h5678, 1'b0, 1'b0, 1'b1);   // missing gives dot sentinel
    send_req(16'h0001, 16'h0001, 1'b0, 1'b1, 1'b0);   // lone last_vector, no effect
    send_req(16'h0002, 16'h0002, 1'b1, 1'b1, 1'b0);
    send_req(16'h0005, 16'h0005, 1'b0, 1'b0, 1'b0);   // partial example dropped
    send_req(16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1);
    send_req(16'hFFFF, 16'h0001, 1'b0, 1'b0, 1'b0);   // negative dot product
    send_req(16'hFFFF, 16'h0001, 1'b1, 1'b1, 1'b0);

    // ---- directed: distance mode ----
    write_mode(MODE_DIST);
    send_req(16'h7FFF, 16'h8000, 1'b1, 1'b1, 1'b0);   // largest distance term
    send_req(16'h0000, 16'h0000, 1'b1, 1'b0, 1'b0);   // zero distance is best
    send_req(16'h0064, 16'hFF9C, 1'b1, 1'b1, 1'b0);
    send_req(16'h0000, 16'h0000, 1'b1, 1'b1, 1'b1);   // distance sentinel
    send_req(16'h0003, 16'h0001, 1'b0, 1'b0, 1'b0);   // mode change mid-vector
    write_mode(MODE_DOT);
    send_req(16'h0004, 16'h0005, 1'b1, 1'b0, 1'b0);   // vector ends under dot
    write_mode(MODE_DIST);
    send_req(16'h0002, 16'h0002, 1'b1, 1'b1, 1'b0);   // example ends under distance
    send_req(16'h0010, 16'h0000, 1'b0, 1'b0, 1'b0);   // partial, then missing under dot
    write_mode(MODE_DOT);
    send_req(16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1);

    // ---- random phase, in chunks with mode writes between them ----
    for (k = 0; k < 8; k++) begin
      chunk_end = sent + 40;
      if (k == 2) begin
        // receiver holds off while the sender keeps offering one-element
        // examples, so the compare stage, queue and s_tready back up
        hold_left = STALL_LEN;
        push_hard = 1;
        repeat (40) send_req(pick_elem(), pick_elem(), 1'b1, 1'b1, 1'b0);
        push_hard = 0;
      end
      if (k == 4) begin
        long_len = VEC_LEN_CAP + $urandom_range(2, 10);
        long_vector(long_len);
      end
      calm = (k == 5);
      while (sent < chunk_end) random_example();
      calm = 0;
      write_mode((k % 2 == 0) ? MODE_DIST : MODE_DOT);
    end

    wait_drain();
    repeat (4 * DRAIN_GAP) @(posedge clk);

    $display("Covered %0d requests and %0d scores (%0d dot, %0d distance, %0d sentinel),",
             sent, sb.checked, sb.dot_scores, sb.dist_scores, sb.sentinels);
    $display("with a %0d-element vector and a %0d-cycle output hold-off.",
             long_len, STALL_LEN);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
